/* src/permutation_unrank_macros.svh */
`ifndef PERMUTATION_UNRANK_MACROS_SVH
`define PERMUTATION_UNRANK_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted
`define PU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted
`define PU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pu_pkg.sv */
package pu_pkg;

  localparam int SYM_CNT    = 10;
  localparam int SYM_W      = 4;
  localparam int RANK_W     = 22;
  localparam int MULT_W     = 23;
  localparam int PROD_W     = RANK_W + MULT_W;
  localparam int SHIFT_W    = 5;
  // two register stages per digit: reciprocal product, then digit and pick
  localparam int NUM_STAGES = 2 * SYM_CNT;

  typedef logic [SYM_CNT-1:0][SYM_W-1:0] sym_vec_t;

  typedef struct packed {
    logic [RANK_W-1:0] rest;
    logic [PROD_W-1:0] prod;
    sym_vec_t          pool;
    sym_vec_t          slots;
  } stage_t;

  // Radix of each digit, most significant place last
  localparam logic [SYM_W-1:0] RADIX [SYM_CNT] = '{
    4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1
  };

  // ceil(2^SHIFT / radix); exact quotient for any 22-bit dividend
  localparam logic [MULT_W-1:0] MULT [SYM_CNT] = '{
    23'd6710887, 23'd7456541, 23'd4194304, 23'd4793491, 23'd5592406,
    23'd6710887, 23'd4194304, 23'd5592406, 23'd4194304, 23'd4194304
  };

  localparam logic [SHIFT_W-1:0] SHIFT [SYM_CNT] = '{
    5'd26, 5'd26, 5'd25, 5'd25, 5'd25, 5'd25, 5'd24, 5'd24, 5'd23, 5'd22
  };

  localparam sym_vec_t INIT_POOL = {
    4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0
  };

endpackage

/* src/pu_in_if.sv */
interface pu_in_if
  import pu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

/* src/pu_out_if.sv */
interface pu_out_if
  import pu_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] slot_0;
  logic [SYM_W-1:0] slot_1;
  logic [SYM_W-1:0] slot_2;
  logic [SYM_W-1:0] slot_3;
  logic [SYM_W-1:0] slot_4;
  logic [SYM_W-1:0] slot_5;
  logic [SYM_W-1:0] slot_6;
  logic [SYM_W-1:0] slot_7;
  logic [SYM_W-1:0] slot_8;
  logic [SYM_W-1:0] slot_9;

  modport source (
    output valid, output slot_0, output slot_1, output slot_2, output slot_3,
    output slot_4, output slot_5, output slot_6, output slot_7, output slot_8,
    output slot_9, input ready
  );
  modport sink (
    input valid, input slot_0, input slot_1, input slot_2, input slot_3,
    input slot_4, input slot_5, input slot_6, input slot_7, input slot_8,
    input slot_9, output ready
  );
endinterface

/* src/permutation_unrank.sv */
// Permutation unranking: turns a rank below ten factorial into the ordering
// of the symbols 0..9 that it names, all ten slots in one result.
// in_ch carries one rank per transaction (valid/ready); out_ch carries the
// ten slots of the matching permutation, in the same order as the ranks.
// A rank of ten factorial or more wraps, as the top mixed-radix digit has
// radix one.
// Pipeline: two register stages per digit (a reciprocal multiply, then
// the digit, the pick and the pool update). Throughput: one rank per
// cycle, as every stage hands its item on in each cycle that out_ch is
// not stalled. Each stage holds its item until the one after it has
// room, so empty stages still fill while out_ch is stalled; in_ch.ready
// drops only once every stage holds an item and out_ch.ready is low.
// Nothing is lost or repeated under stalls.
// rst_n (synchronous, active low) empties the pipeline; no item is kept.
`include "permutation_unrank_macros.svh"

module permutation_unrank
  import pu_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  pu_in_if.sink    in_ch,
  pu_out_if.source out_ch
);

  stage_t               stg_q [NUM_STAGES+1];
  logic [NUM_STAGES:0]  vq;
  logic [NUM_STAGES-1:0] ld;

  assign stg_q[0].rest  = in_ch.rank;
  assign stg_q[0].prod  = '0;
  assign stg_q[0].pool  = INIT_POOL;
  assign stg_q[0].slots = '0;
  assign vq[0]          = in_ch.valid;

  // A stage may load when it is empty or its own content moves on
  assign ld[NUM_STAGES-1] = !vq[NUM_STAGES] || out_ch.ready;
  assign in_ch.ready      = ld[0];

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    localparam int K = s / 2;
    localparam int LAST = int'(RADIX[K]) - 1;

    stage_t d_nxt;
    stage_t d_r;
    logic   v_r;

    if (s < NUM_STAGES - 1) begin : g_ld
      assign ld[s] = !vq[s+1] || ld[s+1];
    end

    if (s % 2 == 0) begin : g_mul
      always_comb begin
        d_nxt      = stg_q[s];
        d_nxt.prod = PROD_W'(stg_q[s].rest) * PROD_W'(MULT[K]);
      end
    end else begin : g_pick
      logic [RANK_W-1:0] quo;
      logic [SYM_W-1:0]  digit;
      logic [SYM_W-1:0]  lo_prod;

      always_comb begin
        quo     = RANK_W'(stg_q[s].prod >> SHIFT[K]);
        // only the low bits of rest - quo * radix are needed: digit < radix
        lo_prod = quo[SYM_W-1:0] * RADIX[K];
        digit   = stg_q[s].rest[SYM_W-1:0] - lo_prod;
        d_nxt             = stg_q[s];
        d_nxt.rest        = quo;
        d_nxt.slots[K]    = stg_q[s].pool[digit];
        // fill the picked entry from the last live one
        d_nxt.pool[digit] = stg_q[s].pool[LAST];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (ld[s]) begin
        v_r <= vq[s];
      end
    end

    always_ff @(posedge clk) begin
      if (ld[s] && vq[s]) begin
        d_r <= d_nxt;
      end
    end

    assign stg_q[s+1] = d_r;
    assign vq[s+1]    = v_r;
  end

  assign out_ch.valid  = vq[NUM_STAGES];
  assign out_ch.slot_0 = stg_q[NUM_STAGES].slots[0];
  assign out_ch.slot_1 = stg_q[NUM_STAGES].slots[1];
  assign out_ch.slot_2 = stg_q[NUM_STAGES].slots[2];
  assign out_ch.slot_3 = stg_q[NUM_STAGES].slots[3];
  assign out_ch.slot_4 = stg_q[NUM_STAGES].slots[4];
  assign out_ch.slot_5 = stg_q[NUM_STAGES].slots[5];
  assign out_ch.slot_6 = stg_q[NUM_STAGES].slots[6];
  assign out_ch.slot_7 = stg_q[NUM_STAGES].slots[7];
  assign out_ch.slot_8 = stg_q[NUM_STAGES].slots[8];
  assign out_ch.slot_9 = stg_q[NUM_STAGES].slots[9];

  // Symbols present in the delivered result
  logic [15:0] slot_mask;
  always_comb begin
    slot_mask = '0;
    for (int i = 0; i < SYM_CNT; i++) begin
      slot_mask = slot_mask | (16'd1 << stg_q[NUM_STAGES].slots[i]);
    end
  end

  `PU_ASSERT_NOW(a_perm_complete, clk, rst_n, out_ch.valid, slot_mask == 16'h03FF, "result is not a permutation of 0..9")
  `PU_ASSERT_NOW(a_ready_when_space, clk, rst_n, !vq[NUM_STAGES] || out_ch.ready, in_ch.ready, "input blocked with room in the pipeline")
  `PU_ASSERT_NOW(a_full_when_blocked, clk, rst_n, !in_ch.ready, &vq[NUM_STAGES:1], "input blocked while a stage is empty")
  `PU_ASSERT_NEXT(a_enter_stage0, clk, rst_n, in_ch.valid && in_ch.ready, vq[1], "accepted transaction did not reach the first stage")

endmodule

/* dv/tb_permutation_unrank.sv */
`timescale 1ns / 100ps

module tb_permutation_unrank;
  import pu_pkg::*;

  localparam int N_DIR     = 18;
  localparam int N_RANDOM  = 1850;
  localparam int LONG_HOLD = 80;

  // rank 0 gives 0,9,8,...,1; rank 10!-1 gives 9,8,...,0 (slot_0 in the low nibble)
  localparam sym_vec_t ZERO_PERM = {4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd0};
  localparam sym_vec_t TOP_PERM  = {4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9};

  typedef struct {
    logic [RANK_W-1:0] rank;
    bit                known;
    sym_vec_t          perm;
  } rank_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pu_in_if  in_ch ();
  pu_out_if out_ch ();

  permutation_unrank u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sym_vec_t  perm_q [$];
  sym_vec_t  exp_fixed = '0;
  bit        exp_known = 1'b0;
  int        errors = 0;
  int        perms_checked = 0;
  int        holds_done = 0;
  rank_row_t dir_rows [N_DIR];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // Mixed-radix digits pick from the unused symbols; the last live one fills the gap
  function automatic sym_vec_t unrank_perm(input logic [RANK_W-1:0] r);
    logic [SYM_W-1:0] avail [SYM_CNT];
    int unsigned      left;
    int unsigned      base;
    int unsigned      sel;
    sym_vec_t         perm;
    left = r;
    for (int i = 0; i < SYM_CNT; i++) avail[i] = SYM_W'(i);
    for (int step = 0; step < SYM_CNT; step++) begin
      base        = SYM_CNT - step;
      sel         = left % base;
      left        = left / base;
      perm[step]  = avail[sel];
      avail[sel]  = avail[base - 1];
    end
    return perm;
  endfunction

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [RANK_W-1:0] random_rank();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return RANK_W'($urandom_range(0, 3628799));
    if (roll < 95) return RANK_W'($urandom_range(3628800, 4194303));
    return RANK_W'($urandom);
  endfunction

  function automatic void note_fail(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // Offer one rank; returns at the falling edge after its transaction
  task automatic offer_rank(input logic [RANK_W-1:0] r, input bit known, input sym_vec_t perm,
                            input bit busy);
    int gap;
    gap = busy ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rank  <= r;
    exp_fixed   <= perm;
    exp_known   <= known;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_perms();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (perm_q.size() != 0);
  endtask

  always @(posedge clk) begin : score
    sym_vec_t got;
    sym_vec_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        perm_q.push_back(exp_known ? exp_fixed : unrank_perm(in_ch.rank));
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.slot_9, out_ch.slot_8, out_ch.slot_7, out_ch.slot_6, out_ch.slot_5,
               out_ch.slot_4, out_ch.slot_3, out_ch.slot_2, out_ch.slot_1, out_ch.slot_0};
        if (perm_q.size() == 0) begin
          note_fail($sformatf("unexpected result after %0d: %h", perms_checked, got));
        end else begin
          want = perm_q.pop_front();
          for (int i = 0; i < SYM_CNT; i++)
            if (got[i] !== want[i])
              note_fail($sformatf("result %0d slot_%0d: expected %0d, got %0d",
                                  perms_checked, i, want[i], got[i]));
        end
        perms_checked++;
      end
    end
  end

  // Result side: random back-pressure, two long hold-offs and one stretch held open
  initial begin : sink
    int hold;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (holds_done < 2 && perms_checked >= 450 + 850 * holds_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
      end else if (perms_checked >= 600 && perms_checked < 800) begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end else begin
        hold = idle_len();
        if (hold > 0) begin
          out_ch.ready <= 1'b0;
          repeat (hold) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin : source
    in_ch.valid = 1'b0;
    in_ch.rank  = '0;
    dir_rows = '{
      '{22'd0,       1'b1, ZERO_PERM},
      '{22'd3628799, 1'b1, TOP_PERM},
      '{22'd3628800, 1'b1, ZERO_PERM},
      '{22'd4194303, 1'b0, '0},
      '{22'd1,       1'b0, '0},
      '{22'd9,       1'b0, '0},
      '{22'd10,      1'b0, '0},
      '{22'd89,      1'b0, '0},
      '{22'd90,      1'b0, '0},
      '{22'd719,     1'b0, '0},
      '{22'd720,     1'b0, '0},
      '{22'd362879,  1'b0, '0},
      '{22'd362880,  1'b0, '0},
      '{22'd1814399, 1'b0, '0},
      '{22'h2AAAAA,  1'b0, '0},
      '{22'h155555,  1'b0, '0},
      '{22'd3628801, 1'b0, '0},
      '{22'd3999999, 1'b0, '0}
    };
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      offer_rank(dir_rows[i].rank, dir_rows[i].known, dir_rows[i].perm, 1'b0);
    drain_perms();

    for (int n = 0; n < N_RANDOM; n++) begin
      // hold back until the pipeline is empty once mid-run
      if (n == 1000) drain_perms();
      offer_rank(random_rank(), 1'b0, '0, n >= 400 && n < 600);
    end

    drain_perms();
    repeat (2 * NUM_STAGES + 10) @(negedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
